// ----- src/tdps_pkg.sv -----
`default_nettype none

package tdps_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_PRESCALER = 2'd0;
   localparam logic [1:0] CSR_MODE      = 2'd1;
   localparam logic [1:0] CSR_COMPARE   = 2'd2;

   // Request type codes
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_EVENT = 1'b1;

   // Timer mode codes
   localparam logic MODE_OVERFLOW = 1'b0;
   localparam logic MODE_COMPARE  = 1'b1;

   localparam logic [8:0] PERIOD_OVERFLOW = 9'd256;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EVAL
   } state_type;

   // Prescaler code to right shift amount (dividers are powers of two)
   function automatic logic [3:0] prescale_shift(input logic [2:0] code);
      logic [3:0] sh;
      begin
         case (code)
            3'd2:    sh = 4'd3;
            3'd3:    sh = 4'd6;
            3'd4:    sh = 4'd8;
            3'd5:    sh = 4'd10;
            3'd6:    sh = 4'd10;
            3'd7:    sh = 4'd10;
            default: sh = 4'd0;
         endcase
         return sh;
      end
   endfunction

endpackage

`default_nettype wire

// ----- src/tdps_if.sv -----
`default_nettype none

interface tdps_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [15:0] delay_ms;

   modport source (output valid, output req_type, output delay_ms, input ready);
   modport sink   (input valid, input req_type, input delay_ms, output ready);
endinterface

interface tdps_rsp_if;
   logic       valid;
   logic       ready;
   logic       load_counter;
   logic [7:0] load_value;
   logic       delay_done;
   logic       timer_running;

   modport source (output valid, output load_counter, output load_value,
                   output delay_done, output timer_running, input ready);
   modport sink   (input valid, input load_counter, input load_value,
                   input delay_done, input timer_running, output ready);
endinterface

`default_nettype wire

// ----- src/tdps_div.sv -----
`default_nettype none

// Restoring divider: one quotient bit per cycle, divisor up to 256.
module tdps_div #(
   parameter int unsigned DW = 29
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [8:0]    divisor,
   output logic               done,
   output logic [DW-1:0]      quotient,
   output logic [7:0]         remainder
);

   localparam int unsigned CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] dq_ff, dq_in;
   logic [8:0]    rem_ff, rem_in;
   logic [8:0]    trial;
   logic          fits;

   // Shift in the next dividend bit and try the subtraction
   always_comb begin
      trial   = {rem_ff[7:0], dq_ff[DW-1]};
      fits    = (trial >= divisor);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW);
         dq_in   = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? (trial - divisor) : trial;
         dq_in  = {dq_ff[DW-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = dq_ff;
   assign remainder = rem_ff[7:0];

endmodule

`default_nettype wire

// ----- src/timer_delay_period_scheduler_top.sv -----
// Long delay scheduler for an 8-bit timer.
// Input channel req_chan carries transactions: a start (req_type 0) with a
// delay in milliseconds, or a timer overflow/compare event (req_type 1).
// Every accepted transaction yields exactly one transaction on rsp_chan:
// load_counter/load_value ask for a counter preload, delay_done marks the
// end of the delay, timer_running tells whether the timer must keep running.
// Configuration (prescaler code, timer mode, compare value) is to be written
// over csr_wr_en/csr_index/csr_wr_data while the block is idle; the block
// itself does not enforce this. An event passes the evaluate state, which
// registers its result once the output register is free. A start passes
// the multiply state, the divider launch state, then the restoring divider,
// which yields one quotient bit per cycle of its DW-bit dividend, with
// DW = 16 + bits of CLOCK_HZ/1000, splitting timer clocks into periods, and
// then the evaluate state. No new transaction is taken before the previous
// result is registered; the next can be accepted as soon as it is.
// One transaction is in work at a time; req_chan.ready is high only when
// the sequencer is idle. A finished result waits in an output register
// while the receiver stalls, and the next transaction may be accepted.
// Synchronous reset returns the block to idle with no delay pending and
// loads the configuration defaults (/1, overflow mode, compare 255).
`default_nettype none

module timer_delay_period_scheduler_top #(
   parameter int unsigned CLOCK_HZ = 8000000
) (
   input  wire logic       clock,
   input  wire logic       reset,
   tdps_req_if.sink        req_chan,
   tdps_rsp_if.source      rsp_chan,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wr_data
);

   localparam int unsigned KVAL = CLOCK_HZ / 1000;
   localparam int unsigned KW   = $clog2(KVAL + 1);
   localparam int unsigned DW   = 16 + KW;
   localparam logic [KW-1:0] K_C = KW'(KVAL);

   // Configuration registers
   logic [2:0] prescaler_ff;
   logic       mode_ff;
   logic [7:0] compare_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prescaler_ff <= 3'd1;
         mode_ff      <= tdps_pkg::MODE_OVERFLOW;
         compare_ff   <= 8'd255;
      end else if (csr_wr_en) begin
         case (csr_index)
            tdps_pkg::CSR_PRESCALER: prescaler_ff <= csr_wr_data[2:0];
            tdps_pkg::CSR_MODE:      mode_ff      <= csr_wr_data[0];
            tdps_pkg::CSR_COMPARE:   compare_ff   <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Current period: 256 in overflow mode, compare value in compare mode, zero counts as 256
   logic [8:0] period;
   assign period = (mode_ff == tdps_pkg::MODE_COMPARE && compare_ff != 8'd0)
                   ? {1'b0, compare_ff} : tdps_pkg::PERIOD_OVERFLOW;

   tdps_pkg::state_type state_ff, state_in;

   logic          type_ff, type_in;
   logic [15:0]   ms_ff, ms_in;
   logic [DW-1:0] prod_ff, prod_in;

   logic          active_ff, active_in;
   logic [31:0]   elapsed_ff, elapsed_in;
   logic [31:0]   full_ff, full_in;
   logic [7:0]    rem_ff, rem_in;
   logic [8:0]    per_ff, per_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          load_ff, load_in;
   logic [7:0]    lval_ff, lval_in;
   logic          done_ff, done_in;
   logic          run_ff, run_in;

   logic          div_start;
   logic          div_done;
   logic [DW-1:0] div_quot;
   logic [7:0]    div_rem;
   logic [DW-1:0] div_dividend;

   logic          out_free;
   logic          cur_act;
   logic [31:0]   cur_el;
   logic [31:0]   cur_full;
   logic [7:0]    cur_rem;
   logic [8:0]    cur_per;
   logic [8:0]    diff;

   assign div_dividend = prod_ff >> tdps_pkg::prescale_shift(prescaler_ff);

   tdps_div #(.DW(DW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (period),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Sequencer: next state, delay bookkeeping and result
   always_comb begin
      state_in     = state_ff;
      type_in      = type_ff;
      ms_in        = ms_ff;
      prod_in      = prod_ff;
      active_in    = active_ff;
      elapsed_in   = elapsed_ff;
      full_in      = full_ff;
      rem_in       = rem_ff;
      per_in       = per_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      load_in      = load_ff;
      lval_in      = lval_ff;
      done_in      = done_ff;
      run_in       = run_ff;
      div_start    = 1'b0;

      // Working view: fresh split on a start, stored values on an event
      if (type_ff == tdps_pkg::REQ_START) begin
         cur_act  = 1'b1;
         cur_el   = '0;
         cur_full = 32'(div_quot);
         cur_rem  = div_rem;
         cur_per  = period;
      end else begin
         cur_act  = active_ff;
         cur_el   = elapsed_ff;
         cur_full = full_ff;
         cur_rem  = rem_ff;
         cur_per  = per_ff;
      end
      diff = cur_per - {1'b0, cur_rem};

      case (state_ff)
         tdps_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               type_in  = req_chan.req_type;
               ms_in    = req_chan.delay_ms;
               state_in = (req_chan.req_type == tdps_pkg::REQ_START)
                          ? tdps_pkg::ST_MUL : tdps_pkg::ST_EVAL;
            end
         end
         tdps_pkg::ST_MUL: begin
            prod_in  = DW'(ms_ff) * DW'(K_C);
            state_in = tdps_pkg::ST_DIV_START;
         end
         tdps_pkg::ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = tdps_pkg::ST_DIV_WAIT;
         end
         tdps_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = tdps_pkg::ST_EVAL;
            end
         end
         tdps_pkg::ST_EVAL: begin
            if (out_free) begin
               state_in     = tdps_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               load_in      = 1'b0;
               lval_in      = '0;
               done_in      = 1'b0;
               run_in       = 1'b0;
               if (cur_act) begin
                  active_in  = 1'b1;
                  full_in    = cur_full;
                  rem_in     = cur_rem;
                  per_in     = cur_per;
                  elapsed_in = cur_el;
                  run_in     = 1'b1;
                  if (cur_el < cur_full) begin
                     elapsed_in = cur_el + 32'd1;
                  end else if (cur_el == cur_full && cur_rem != 8'd0) begin
                     load_in    = 1'b1;
                     lval_in    = diff[7:0];
                     elapsed_in = cur_el + 32'd1;
                  end else begin
                     done_in    = 1'b1;
                     run_in     = 1'b0;
                     active_in  = 1'b0;
                     elapsed_in = '0;
                     full_in    = '0;
                     rem_in     = '0;
                     per_in     = '0;
                  end
               end
            end
         end
         default: begin
            state_in = tdps_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdps_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
         elapsed_ff   <= '0;
         full_ff      <= '0;
         rem_ff       <= '0;
         per_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         elapsed_ff   <= elapsed_in;
         full_ff      <= full_in;
         rem_ff       <= rem_in;
         per_ff       <= per_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      type_ff <= type_in;
      ms_ff   <= ms_in;
      prod_ff <= prod_in;
      load_ff <= load_in;
      lval_ff <= lval_in;
      done_ff <= done_in;
      run_ff  <= run_in;
   end

   assign req_chan.ready         = (state_ff == tdps_pkg::ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.load_counter  = load_ff;
   assign rsp_chan.load_value    = lval_ff;
   assign rsp_chan.delay_done    = done_ff;
   assign rsp_chan.timer_running = run_ff;

endmodule

`default_nettype wire

// ----- dv/tb_timer_delay_period_scheduler_top.sv -----
module tb_timer_delay_period_scheduler_top;

   localparam int unsigned CLOCK_HZ        = 8000000;
   localparam int unsigned TICKS_PER_MS    = CLOCK_HZ / 1000;
   localparam int unsigned SEQ_PERIODS_MAX = 48;
   localparam int unsigned HOLD_CYCLES     = 400;
   localparam int unsigned DRAIN_CYCLES    = 60;
   localparam int unsigned PHASE_ITEMS     = 150;
   localparam logic [1:0]  CSR_UNMAPPED    = 2'd3;

   typedef struct packed {
      logic        req_type;
      logic [15:0] delay_ms;
   } timer_req_type;

   typedef struct packed {
      logic       load_counter;
      logic [7:0] load_value;
      logic       delay_done;
      logic       timer_running;
   } delay_step_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       csr_wr_en   = 1'b0;
   logic [1:0] csr_index   = tdps_pkg::CSR_PRESCALER;
   logic [7:0] csr_wr_data = 8'd0;

   tdps_req_if req_chan();
   tdps_rsp_if rsp_chan();

   timer_delay_period_scheduler_top #(.CLOCK_HZ(CLOCK_HZ)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow configuration
   logic [2:0] cfg_prescale;
   logic       cfg_mode;
   logic [7:0] cfg_compare;

   // Shadow delay state
   logic        dly_active;
   logic [31:0] periods_elapsed;
   logic [31:0] periods_full;
   logic [7:0]  rem_clocks;
   logic [8:0]  period_len;

   timer_req_type  timer_reqs[$];
   delay_step_type delay_steps_due[$];
   int unsigned reqs_queued = 0;
   int unsigned reqs_taken  = 0;
   int unsigned mismatches  = 0;
   int unsigned hold_requests = 0;
   logic        calm = 1'b0;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("FAIL");
      $finish;
   end

   function automatic int unsigned clock_divider(input logic [2:0] code);
      case (code)
         3'd2:                   return 8;
         3'd3:                   return 64;
         3'd4:                   return 256;
         3'd5, 3'd6, 3'd7:       return 1024;
         default:                return 1;
      endcase
   endfunction

   function automatic logic [8:0] active_period();
      logic [8:0] per;
      per = (cfg_mode == tdps_pkg::MODE_COMPARE) ? {1'b0, cfg_compare}
                                                 : tdps_pkg::PERIOD_OVERFLOW;
      // compare value zero behaves as the full overflow period
      if (per == 9'd0) per = tdps_pkg::PERIOD_OVERFLOW;
      return per;
   endfunction

   function automatic longint unsigned timer_clocks(input logic [15:0] ms);
      return (64'(ms) * 64'(TICKS_PER_MS)) / 64'(clock_divider(cfg_prescale));
   endfunction

   // Advance the shadow delay by one transaction and return the expected step
   function automatic delay_step_type advance_delay(input timer_req_type req);
      delay_step_type    step;
      longint unsigned   clocks;
      step = '0;
      if (req.req_type == tdps_pkg::REQ_START) begin
         period_len      = active_period();
         clocks          = timer_clocks(req.delay_ms);
         periods_full    = 32'(clocks / 64'(period_len));
         rem_clocks      = 8'(clocks % 64'(period_len));
         periods_elapsed = '0;
         dly_active      = 1'b1;
      end else if (!dly_active) begin
         return step;
      end
      if (periods_elapsed < periods_full) begin
         periods_elapsed++;
      end else if (periods_elapsed == periods_full && rem_clocks != 8'd0) begin
         step.load_counter = 1'b1;
         step.load_value   = 8'(period_len - {1'b0, rem_clocks});
         periods_elapsed++;
      end else begin
         step.delay_done = 1'b1;
         dly_active      = 1'b0;
         periods_elapsed = '0;
         periods_full    = '0;
         rem_clocks      = '0;
         period_len      = '0;
      end
      step.timer_running = dly_active;
      return step;
   endfunction

   // Number of events that take a fresh delay of ms to completion
   function automatic int unsigned events_to_done(input logic [15:0] ms);
      longint unsigned clocks;
      logic [8:0]      per;
      per    = active_period();
      clocks = timer_clocks(ms);
      return int'(clocks / 64'(per)) + ((clocks % 64'(per)) != 0 ? 1 : 0);
   endfunction

   // Largest delay that still finishes within a bounded number of periods
   function automatic logic [15:0] short_delay_cap();
      longint unsigned c;
      c = (64'(SEQ_PERIODS_MAX) * 64'(active_period()) * 64'(clock_divider(cfg_prescale)))
          / 64'(TICKS_PER_MS);
      return (c > 64'd65535) ? 16'hFFFF : 16'(c);
   endfunction

   function automatic int unsigned gap_len();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 80);
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s expected %0d got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Drive request transactions from the queue
   always @(posedge clock) begin : req_drive
      timer_req_type nxt;
      int unsigned send_gap;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_chan.valid <= 1'b0;
         end else if (timer_reqs.size() != 0) begin
            nxt = timer_reqs.pop_front();
            req_chan.valid    <= 1'b1;
            req_chan.req_type <= nxt.req_type;
            req_chan.delay_ms <= nxt.delay_ms;
            send_gap = gap_len();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Predict on accepted requests, check accepted results, pace the receiver
   always @(posedge clock) begin : rsp_check
      timer_req_type  seen;
      delay_step_type want;
      int unsigned stall_left;
      int unsigned hold_left;
      int unsigned hold_seen;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
         hold_seen  = hold_requests;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            seen.req_type = req_chan.req_type;
            seen.delay_ms = req_chan.delay_ms;
            delay_steps_due.push_back(advance_delay(seen));
            reqs_taken++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (delay_steps_due.size() == 0) begin
               $error("result transaction with no expectation pending");
               mismatches++;
            end else begin
               want = delay_steps_due.pop_front();
               check_field("load_counter", want.load_counter, rsp_chan.load_counter);
               check_field("load_value", want.load_value, rsp_chan.load_value);
               check_field("delay_done", want.delay_done, rsp_chan.delay_done);
               check_field("timer_running", want.timer_running, rsp_chan.timer_running);
            end
            stall_left = gap_len();
         end
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic push_req(input logic kind, input logic [15:0] ms);
      timer_req_type t;
      t.req_type = kind;
      t.delay_ms = ms;
      timer_reqs.push_back(t);
      reqs_queued++;
   endtask

   task automatic wait_drained();
      while (!(reqs_taken == reqs_queued && delay_steps_due.size() == 0)) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      case (idx)
         tdps_pkg::CSR_PRESCALER: cfg_prescale = data[2:0];
         tdps_pkg::CSR_MODE:      cfg_mode     = data[0];
         tdps_pkg::CSR_COMPARE:   cfg_compare  = data;
         default: ;
      endcase
   endtask

   // Write all registers, optionally with junk in the unused bits and a write to the unmapped index
   task automatic apply_config(input logic [2:0] code, input logic mode, input logic [7:0] cmp,
                               input logic junk);
      write_reg(tdps_pkg::CSR_PRESCALER, {junk ? 5'($urandom) : 5'd0, code});
      write_reg(tdps_pkg::CSR_MODE, {junk ? 7'($urandom) : 7'd0, mode});
      write_reg(tdps_pkg::CSR_COMPARE, cmp);
      if (junk) write_reg(CSR_UNMAPPED, 8'($urandom));
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly complete delays with random content, plus idle events and abandoned delays
   task automatic fill_random(input int unsigned n);
      int unsigned first, r, evts, cut, k, extra;
      logic [15:0] ms, cap;
      first = reqs_queued;
      while (reqs_queued - first < n) begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            cap  = short_delay_cap();
            ms   = ($urandom_range(0, 3) == 0) ? cap : 16'($urandom_range(0, cap));
            evts = events_to_done(ms);
            cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, evts) : evts;
            push_req(tdps_pkg::REQ_START, ms);
            for (k = 0; k < cut; k++) push_req(tdps_pkg::REQ_EVENT, 16'($urandom));
            if (cut == evts && $urandom_range(0, 3) == 0) begin
               push_req(tdps_pkg::REQ_EVENT, 16'($urandom));
            end
         end else if (r < 88) begin
            push_req(tdps_pkg::REQ_EVENT, 16'($urandom));
         end else begin
            push_req(tdps_pkg::REQ_START, 16'($urandom));
            extra = $urandom_range(0, 4);
            for (k = 0; k < extra; k++) push_req(tdps_pkg::REQ_EVENT, 16'($urandom));
         end
      end
      // zero-length start leaves the block idle for the next configuration
      push_req(tdps_pkg::REQ_START, 16'd0);
   endtask

   task automatic run_phase(input logic [2:0] code, input logic mode, input logic [7:0] cmp,
                            input logic quiet, input logic long_hold);
      wait_drained();
      apply_config(code, mode, cmp, 1'($urandom_range(0, 1)));
      calm = quiet;
      if (long_hold) hold_requests++;
      fill_random(PHASE_ITEMS);
   endtask

   initial begin
      req_chan.valid    = 1'b0;
      req_chan.req_type = tdps_pkg::REQ_EVENT;
      req_chan.delay_ms = 16'd0;
      rsp_chan.ready    = 1'b0;
      cfg_prescale      = 3'd1;
      cfg_mode          = tdps_pkg::MODE_OVERFLOW;
      cfg_compare       = 8'd255;
      dly_active        = 1'b0;
      periods_elapsed   = '0;
      periods_full      = '0;
      rem_clocks        = '0;
      period_len        = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: idle events, zero-length delay, restart of a long delay
      push_req(tdps_pkg::REQ_EVENT, 16'd0);
      push_req(tdps_pkg::REQ_EVENT, 16'hFFFF);
      push_req(tdps_pkg::REQ_START, 16'd0);
      push_req(tdps_pkg::REQ_START, 16'hFFFF);
      push_req(tdps_pkg::REQ_EVENT, 16'd0);
      push_req(tdps_pkg::REQ_EVENT, 16'hFFFF);
      push_req(tdps_pkg::REQ_START, 16'd1);
      push_req(tdps_pkg::REQ_EVENT, 16'h5A5A);
      push_req(tdps_pkg::REQ_START, 16'd0);
      wait_drained();

      // Delay shorter than one period: preload on the start step
      apply_config(3'd5, tdps_pkg::MODE_COMPARE, 8'd255, 1'b0);
      push_req(tdps_pkg::REQ_START, 16'd1);
      push_req(tdps_pkg::REQ_EVENT, 16'd0);
      push_req(tdps_pkg::REQ_EVENT, 16'd0);
      wait_drained();

      // Exact whole periods, no preload
      apply_config(3'd5, tdps_pkg::MODE_COMPARE, 8'd7, 1'b0);
      push_req(tdps_pkg::REQ_START, 16'd1);
      push_req(tdps_pkg::REQ_EVENT, 16'd0);
      wait_drained();

      // Compare value zero acts as 256, top prescaler code acts as /1024
      apply_config(3'd7, tdps_pkg::MODE_COMPARE, 8'd0, 1'b0);
      push_req(tdps_pkg::REQ_START, 16'd3);
      push_req(tdps_pkg::REQ_EVENT, 16'd0);
      wait_drained();

      // Prescaler code zero acts as /1
      apply_config(3'd0, tdps_pkg::MODE_OVERFLOW, 8'd1, 1'b0);
      push_req(tdps_pkg::REQ_START, 16'd0);
      push_req(tdps_pkg::REQ_START, 16'h8000);
      push_req(tdps_pkg::REQ_EVENT, 16'd0);
      push_req(tdps_pkg::REQ_START, 16'd0);

      // Random phases across the configuration space
      run_phase(3'd0, tdps_pkg::MODE_OVERFLOW, 8'd255, 1'b0, 1'b0);
      run_phase(3'd5, tdps_pkg::MODE_COMPARE, 8'd1, 1'b1, 1'b0);
      run_phase(3'd7, tdps_pkg::MODE_COMPARE, 8'd0, 1'b0, 1'b1);
      run_phase(3'd2, tdps_pkg::MODE_COMPARE, 8'd128, 1'b0, 1'b0);
      run_phase(3'd3, tdps_pkg::MODE_OVERFLOW, 8'd17, 1'b0, 1'b0);
      run_phase(3'd4, tdps_pkg::MODE_COMPARE, 8'd255, 1'b1, 1'b0);
      run_phase(3'd6, tdps_pkg::MODE_COMPARE, 8'd200, 1'b0, 1'b0);
      run_phase(3'd1, tdps_pkg::MODE_COMPARE, 8'd3, 1'b0, 1'b0);
      run_phase(3'd5, tdps_pkg::MODE_OVERFLOW, 8'd255, 1'b0, 1'b0);
      run_phase(3'($urandom), 1'($urandom), 8'($urandom), 1'b0, 1'b0);
      run_phase(3'($urandom), 1'($urandom), 8'($urandom), 1'b0, 1'b0);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && delay_steps_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/tdps_pkg.sv
src/tdps_if.sv
src/tdps_div.sv
src/timer_delay_period_scheduler_top.sv
dv/tb_timer_delay_period_scheduler_top.sv
